FILE: rtl/core/hwst_pkg.sv
package hwst_pkg;

    // Field widths of the pixel stream and the configuration port.
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned BINS_W      = 9;
    localparam int unsigned MASK_WORDS  = 4;
    localparam int unsigned MASK_WORD_W = 64;

    // One divider cell resolves one quotient bit.
    localparam int unsigned QUO_CELLS = PIX_W;

    // Smallest usable bin count.
    localparam logic [BINS_W-1:0] BINS_MIN = 9'd2;

    // Full-scale output level.
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MASK_WORD_0 = 3'd0,
        CFG_MASK_WORD_1 = 3'd1,
        CFG_MASK_WORD_2 = 3'd2,
        CFG_MASK_WORD_3 = 3'd3,
        CFG_BINS_IN_USE = 3'd4
    } cfg_index_t;

    // Work carried down the divider chain for one pixel.
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] word;
        logic [PIX_W-1:0] span;
        logic             byp;
        logic [PIX_W-1:0] byp_val;
    } lane_t;

    // Window levels derived from the configuration.
    typedef struct packed {
        logic             ready;
        logic             any;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] span;
    } window_t;

endpackage

FILE: rtl/core/histogram_window_stretch.sv
// A pixel request passes through three front stages, eight divider cells
// and one output register before its result appears.
// Throughput: one pixel per cycle when the output does not stall; each cell resolves one quotient bit.
// After a configuration write the pixel input is not ready while the bin scan
// and the two level divisions run.
// Reset clears the mask, sets 256 bins and leaves the pipeline empty.
module histogram_window_stretch #(
    parameter int unsigned MAX_BINS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hwst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hwst_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pixel_in_valid,
    output logic                                pixel_in_ready,
    input  logic [hwst_pkg::PIX_W-1:0]          pixel_in,
    output logic                                pixel_out_valid,
    input  logic                                pixel_out_ready,
    output logic [hwst_pkg::PIX_W-1:0]          pixel_out
);

    localparam int unsigned PW    = hwst_pkg::PIX_W;
    localparam int unsigned BW    = hwst_pkg::BINS_W;
    localparam int unsigned IW    = $clog2(MAX_BINS);
    localparam int unsigned WORDS = hwst_pkg::MASK_WORDS;
    localparam int unsigned WW    = hwst_pkg::MASK_WORD_W;
    localparam int unsigned CELLS = hwst_pkg::QUO_CELLS;
    localparam logic [BW-1:0] BINS_CAP = BW'(MAX_BINS);

    // Configuration registers.
    logic [MAX_BINS-1:0] mask_reg;
    logic [BW-1:0]       bins_reg;
    logic                start_reg;
    logic [WORDS-1:0]    mask_wr;
    logic                bins_wr;
    logic                cfg_fire;

    logic [BW-1:0]       bins_eff;
    logic [PW-1:0]       last_bin;
    hwst_pkg::window_t   win;

    // Front stages.
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [PW-1:0]       s1_p_reg, s2_p_reg, s3_p_reg;
    logic [2*PW-1:0]     s2_prod_reg;
    logic [PW-1:0]       s3_idx_reg;
    logic                s1_take, s2_take, s3_take;
    logic                accept;
    logic [2*PW-1:0]     round_sum;
    logic [2*PW-1:0]     quo_sum;

    // Lane entry.
    hwst_pkg::lane_t     entry;
    logic                sel;
    logic [PW-1:0]       diff;
    logic [2*PW-1:0]     num;

    // Divider chain.
    logic                cell_valid [CELLS];
    logic                cell_take  [CELLS];
    logic                cell_down  [CELLS];
    hwst_pkg::lane_t     cell_lane  [CELLS];

    // Output register.
    logic                out_valid_reg;
    logic [PW-1:0]       out_pix_reg;
    logic                out_take;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        mask_wr = '0;
        bins_wr = 1'b0;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                hwst_pkg::CFG_MASK_WORD_0: mask_wr[0] = 1'b1;
                hwst_pkg::CFG_MASK_WORD_1: mask_wr[1] = 1'b1;
                hwst_pkg::CFG_MASK_WORD_2: mask_wr[2] = 1'b1;
                hwst_pkg::CFG_MASK_WORD_3: mask_wr[3] = 1'b1;
                hwst_pkg::CFG_BINS_IN_USE: bins_wr    = 1'b1;
                default:                   bins_wr    = 1'b0;
            endcase
        end
    end

    // Only the bins that can ever be used are stored.
    for (genvar i = 0; i < MAX_BINS; i++)
    begin : g_mask
        localparam int unsigned W = i / WW;
        localparam int unsigned B = i % WW;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mask_reg[i] <= 1'b0;
            end
            else if (mask_wr[W])
            begin
                mask_reg[i] <= cfg_data[B];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg  <= BW'(256);
            start_reg <= 1'b0;
        end
        else
        begin
            if (bins_wr)
            begin
                bins_reg <= cfg_data[BW-1:0];
            end
            start_reg <= cfg_fire;
        end
    end

    // Effective bin count, clamped to the supported range.
    always_comb
    begin
        priority if (bins_reg < hwst_pkg::BINS_MIN)
        begin
            bins_eff = hwst_pkg::BINS_MIN;
        end
        else if (bins_reg > BINS_CAP)
        begin
            bins_eff = BINS_CAP;
        end
        else
        begin
            bins_eff = bins_reg;
        end
    end

    assign last_bin = PW'(bins_eff - BW'(1));

    hwst_setup #(
        .MAX_BINS (MAX_BINS)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .mask     (mask_reg),
        .last_bin (last_bin),
        .win      (win)
    );

    // Input handshake: held off while the window levels are being derived or the front stages are full.
    assign s3_take        = !s3_valid_reg || cell_take[0];
    assign s2_take        = !s2_valid_reg || s3_take;
    assign s1_take        = !s1_valid_reg || s2_take;
    assign pixel_in_ready = win.ready && !start_reg && s1_take;
    assign accept         = pixel_in_valid && pixel_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_take)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Bin index of the pixel: round(p*d/255) = (p*d + 127) / 255.
    assign round_sum = s2_prod_reg + (2 * PW)'(127);
    assign quo_sum   = round_sum + (2 * PW)'(round_sum[2*PW-1:PW]) + (2 * PW)'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_p_reg <= pixel_in;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_p_reg    <= s1_p_reg;
            s2_prod_reg <= (2 * PW)'(s1_p_reg) * (2 * PW)'(last_bin);
        end
        if (s3_take && s2_valid_reg)
        begin
            s3_p_reg   <= s2_p_reg;
            s3_idx_reg <= quo_sum[2*PW-1:PW];
        end
    end

    // Classify the pixel and load the numerator (p - lo) * 255.
    assign sel  = mask_reg[s3_idx_reg[IW-1:0]];
    assign diff = s3_p_reg - win.lo;
    assign num  = {diff, PW'(0)} - (2 * PW)'(diff);

    always_comb
    begin
        entry.rem     = num[2*PW-1:PW];
        entry.word    = num[PW-1:0];
        entry.span    = win.span;
        entry.byp     = 1'b1;
        entry.byp_val = '0;
        priority if (!win.any)
        begin
            entry.byp_val = s3_p_reg;
        end
        else if (s3_p_reg >= win.hi)
        begin
            entry.byp_val = hwst_pkg::PIX_MAX;
        end
        else if (s3_p_reg <= win.lo)
        begin
            entry.byp_val = '0;
        end
        else if (!sel)
        begin
            entry.byp_val = '0;
        end
        else
        begin
            entry.byp = 1'b0;
        end
    end

    // Chain of divider cells, one quotient bit each.
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        if (c == CELLS - 1)
        begin : g_last
            assign cell_down[c] = out_take;
        end
        else
        begin : g_mid
            assign cell_down[c] = cell_take[c + 1];
        end

        if (c == 0)
        begin : g_first
            hwst_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (s3_valid_reg),
                .up_lane   (entry),
                .up_take   (cell_take[c]),
                .down_take (cell_down[c]),
                .valid     (cell_valid[c]),
                .lane      (cell_lane[c])
            );
        end
        else
        begin : g_next
            hwst_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .up_valid  (cell_valid[c - 1]),
                .up_lane   (cell_lane[c - 1]),
                .up_take   (cell_take[c]),
                .down_take (cell_down[c]),
                .valid     (cell_valid[c]),
                .lane      (cell_lane[c])
            );
        end
    end

    // Output register parts the chain from the result consumer.
    assign out_take = !out_valid_reg || pixel_out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= cell_valid[CELLS - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && cell_valid[CELLS - 1])
        begin
            out_pix_reg <= cell_lane[CELLS - 1].byp ? cell_lane[CELLS - 1].byp_val
                                                    : cell_lane[CELLS - 1].word;
        end
    end

    assign pixel_out_valid = out_valid_reg;
    assign pixel_out       = out_pix_reg;

endmodule

FILE: rtl/core/hwst_cell.sv
module hwst_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  hwst_pkg::lane_t up_lane,
    output logic          up_take,
    input  logic          down_take,
    output logic          valid,
    output hwst_pkg::lane_t lane
);

    localparam int unsigned PW = hwst_pkg::PIX_W;

    logic            valid_reg;
    hwst_pkg::lane_t lane_reg;
    logic [PW:0]     trial;
    logic            ge;

    // The cell is free when empty or when its content moves on.
    assign up_take = !valid_reg || down_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            lane_reg <= up_lane;
        end
    end

    // One restoring division step: shift in the next numerator bit and
    // subtract the divisor when it fits. The quotient bit enters the word
    // as the numerator bit leaves it.
    always_comb
    begin
        trial = {lane_reg.rem, lane_reg.word[PW-1]};
        ge    = trial >= {1'b0, lane_reg.span};
        lane  = lane_reg;
        lane.rem  = ge ? PW'(trial - {1'b0, lane_reg.span}) : trial[PW-1:0];
        lane.word = {lane_reg.word[PW-2:0], ge};
    end

    assign valid = valid_reg;

endmodule

FILE: rtl/core/hwst_setup.sv
module hwst_setup #(
    parameter int unsigned MAX_BINS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [MAX_BINS-1:0]            mask,
    input  logic [hwst_pkg::PIX_W-1:0]     last_bin,
    output hwst_pkg::window_t              win
);

    localparam int unsigned PW = hwst_pkg::PIX_W;
    localparam int unsigned IW = $clog2(MAX_BINS);
    localparam int unsigned NW = 2 * PW + 1;
    localparam logic [2:0]  STEP_LAST = 3'(PW - 1);

    typedef enum logic [5:0] {
        ST_SCAN    = 6'b000001,
        ST_LOAD_LO = 6'b000010,
        ST_DIV_LO  = 6'b000100,
        ST_LOAD_HI = 6'b001000,
        ST_DIV_HI  = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [2:0]        step_reg, step_next;
    logic              any_reg, any_next;
    logic [MAX_BINS-1:0] bits_reg, bits_next;
    logic [IW-1:0]     mn_reg, mn_next;
    logic [IW-1:0]     mx_reg, mx_next;
    logic [PW:0]       rem_reg, rem_next;
    logic [PW-1:0]     word_reg, word_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [PW-1:0]     span_reg, span_next;

    logic [PW:0]       divisor;
    logic [PW-1:0]     k;
    logic [NW-1:0]     num;
    logic [PW+1:0]     trial;
    logic              ge;
    logic [PW:0]       rem_step;
    logic [PW-1:0]     word_step;

    // Level of bin k is (510*k + d) / (2*d), found one bit a cycle.
    assign divisor = {last_bin, 1'b0};
    assign k       = (state_reg == ST_LOAD_LO) ? PW'(mn_reg) : PW'(mx_reg);
    assign num     = {k, 9'b0} - NW'({k, 1'b0}) + NW'(last_bin);

    assign trial     = {rem_reg, word_reg[PW-1]};
    assign ge        = trial >= {1'b0, divisor};
    assign rem_step  = ge ? (PW + 1)'(trial - {1'b0, divisor}) : trial[PW:0];
    assign word_step = {word_reg[PW-2:0], ge};

    // Sequencer: scan the bins, then divide out the two levels.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        any_next   = any_reg;
        bits_next  = bits_reg;
        mn_next    = mn_reg;
        mx_next    = mx_reg;
        rem_next   = rem_reg;
        word_next  = word_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        span_next  = span_reg;

        unique case (state_reg)
            ST_SCAN:
            begin
                if (bits_reg[0])
                begin
                    if (!any_reg)
                    begin
                        mn_next = cnt_reg;
                    end
                    mx_next  = cnt_reg;
                    any_next = 1'b1;
                end
                bits_next = bits_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == last_bin[IW-1:0])
                begin
                    state_next = ST_LOAD_LO;
                end
            end
            ST_LOAD_LO, ST_LOAD_HI:
            begin
                rem_next   = num[NW-1:PW];
                word_next  = num[PW-1:0];
                step_next  = '0;
                state_next = (state_reg == ST_LOAD_LO) ? ST_DIV_LO : ST_DIV_HI;
            end
            ST_DIV_LO:
            begin
                rem_next  = rem_step;
                word_next = word_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    lo_next    = word_step;
                    state_next = ST_LOAD_HI;
                end
            end
            ST_DIV_HI:
            begin
                rem_next  = rem_step;
                word_next = word_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    hi_next    = word_step;
                    span_next  = word_step - lo_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_DONE;
            end
        endcase

        // A new configuration restarts the scan from the lowest bin.
        if (start)
        begin
            state_next = ST_SCAN;
            bits_next  = mask;
            cnt_next   = '0;
            any_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DONE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            any_reg   <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        mn_reg   <= mn_next;
        mx_reg   <= mx_next;
        rem_reg  <= rem_next;
        word_reg <= word_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        span_reg <= span_next;
    end

    always_comb
    begin
        win.ready = (state_reg == ST_DONE);
        win.any   = any_reg;
        win.lo    = lo_reg;
        win.hi    = hi_reg;
        win.span  = span_reg;
    end

endmodule
